>>> rtl/gapq_pkg.sv
// Package for the key-frame-aware packet descriptor queue.
// Holds field widths, opcode codes, the command and result types and the sequencer states.
// No dependencies.
package gapq_pkg;

  // Field widths of the channel payloads and the configuration register.
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 32;
  localparam int OCC_W    = 7;
  localparam int DROP_W   = 7;
  localparam int MAXE_W   = 6;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Parameter defaults for the top level.
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int HANDLE_BITS_DEF = 32;

  // Reset value of the occupancy limit.
  localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 6'd63;

  // Register index of the occupancy limit (taken from paddr bit 2).
  localparam logic REG_MAX_ENTRIES = 1'b0;

  // Opcode codes on the input channel.
  localparam logic [OP_W-1:0] OPC_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OPC_POP   = 2'd1;
  localparam logic [OP_W-1:0] OPC_CLEAR = 2'd2;

  // Decoded operation carried from the front to the back.
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // One classified command waiting in the command queue.
  typedef struct packed {
    op_e                 op;
    logic [HANDLE_W-1:0] handle;
    logic                key;
  } cmd_t;

  // One result as held in the output register.
  typedef struct packed {
    logic                pop_valid;
    logic [HANDLE_W-1:0] head_handle;
    logic                head_key_frame;
    logic [OCC_W-1:0]    occupancy;
    logic [DROP_W-1:0]   dropped_count;
  } res_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WALK,
    ST_POP
  } st_e;

endpackage

>>> rtl/gapq_intf.sv
// Valid/ready channel interfaces of the key-frame-aware packet queue.
// gapq_in_if carries commands, gapq_out_if carries results; widths come from gapq_pkg.
interface gapq_in_if;
  import gapq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [HANDLE_W-1:0] packet_handle;
  logic                is_key_frame;

  modport source (output valid, opcode, packet_handle, is_key_frame, input ready);
  modport sink   (input valid, opcode, packet_handle, is_key_frame, output ready);
endinterface

interface gapq_out_if;
  import gapq_pkg::*;

  logic                valid;
  logic                ready;
  logic                pop_valid;
  logic [HANDLE_W-1:0] head_handle;
  logic                head_key_frame;
  logic [OCC_W-1:0]    occupancy;
  logic [DROP_W-1:0]   dropped_count;

  modport source (output valid, pop_valid, head_handle, head_key_frame, occupancy,
                  dropped_count, input ready);
  modport sink   (input valid, pop_valid, head_handle, head_key_frame, occupancy,
                  dropped_count, output ready);
endinterface

>>> rtl/gapq_front.sv
// Front end of the packet queue: accepts input transfers, decodes the opcode and
// buffers classified commands in a two-entry queue. Depends on gapq_pkg and gapq_intf.
module gapq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  gapq_in_if.sink       in_chan_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output gapq_pkg::cmd_t cmd_o
);
  import gapq_pkg::*;

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  cmd_t             fifo_q [FQ_DEPTH];
  logic [FQ_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FQ_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FQ_CW-1:0] cnt_q, cnt_d;
  cmd_t             cmd_new;
  logic             in_xfer;
  logic             out_xfer;

  // Classify the incoming opcode.
  always_comb begin
    cmd_new.handle = in_chan_i.packet_handle;
    cmd_new.key    = in_chan_i.is_key_frame;
    case (in_chan_i.opcode)
      OPC_PUSH:  cmd_new.op = OP_PUSH;
      OPC_POP:   cmd_new.op = OP_POP;
      OPC_CLEAR: cmd_new.op = OP_CLEAR;
      default:   cmd_new.op = OP_NOP;
    endcase
  end

  assign in_chan_i.ready = (cnt_q != FQ_CW'(FQ_DEPTH));
  assign in_xfer         = in_chan_i.valid && in_chan_i.ready;
  assign cmd_valid_o     = (cnt_q != '0);
  assign out_xfer        = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = fifo_q[rd_ptr_q];

  // Pointer and fill-count updates.
  always_comb begin
    wr_ptr_d = in_xfer ? wr_ptr_q + FQ_PW'(1) : wr_ptr_q;
    rd_ptr_d = out_xfer ? rd_ptr_q + FQ_PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + FQ_CW'(1);
    end else if (!in_xfer && out_xfer) begin
      cnt_d = cnt_q - FQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> rtl/gapq_back.sv
// Back end of the packet queue: descriptor memory, head/tail pointers, the drop-walk
// sequencer and the output register. Depends on gapq_pkg and gapq_intf.
module gapq_back #(
  parameter int QUEUE_DEPTH = gapq_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = gapq_pkg::HANDLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  gapq_pkg::cmd_t              cmd_i,
  input  logic [gapq_pkg::MAXE_W-1:0] max_entries_i,
  gapq_out_if.source                  out_chan_o
);
  import gapq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > MAXE_W) ? CW : MAXE_W;
  localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  st_e           state_q, state_d;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] drop_q, drop_d;
  logic          first_q, first_d;
  res_t          res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic [SW:0]   mem_q [QUEUE_DEPTH];
  logic [SW:0]   rd_data_q;
  logic          mem_we;
  logic          rd_en;
  logic [PW-1:0] rd_addr;

  logic          out_free;
  logic          start;
  logic [PW-1:0] head_adv;
  logic [PW-1:0] tail_adv;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [CW-1:0] drop_inc;
  logic [LW-1:0] limit;
  logic          over;
  logic          rd_key;
  logic          walk_done;
  logic          res_load;

  // Shared arithmetic for pointers, counts and the limit check.
  assign head_adv  = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign tail_adv  = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PW'(1);
  assign count_inc = count_q + CW'(1);
  assign count_dec = count_q - CW'(1);
  assign drop_inc  = drop_q + CW'(1);
  assign limit     = (LW'(max_entries_i) > LW'(QUEUE_DEPTH - 1)) ? LW'(QUEUE_DEPTH - 1)
                                                                 : LW'(max_entries_i);
  assign over      = (LW'(count_inc) > limit);
  assign rd_key    = rd_data_q[0];
  assign walk_done = rd_key || (count_dec == '0);

  // A new command starts only when the output register will have room for its result.
  assign out_free  = !res_valid_q || out_chan_o.ready;
  assign start     = (state_q == ST_IDLE) && cmd_valid_i && out_free;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.op)
            OP_PUSH: if (over) state_d = ST_RD;
            OP_POP:  if (count_q != '0) state_d = ST_POP;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD:   state_d = ST_WALK;
      ST_WALK: if (walk_done) state_d = ST_IDLE;
      ST_POP:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output logic of the sequencer.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    drop_d      = drop_q;
    first_d     = first_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_q;
    cmd_ready_o = 1'b0;
    res_load    = 1'b0;
    res_d       = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.op)
            OP_PUSH: begin
              mem_we  = 1'b1;
              tail_d  = tail_adv;
              count_d = count_inc;
              drop_d  = '0;
              first_d = 1'b1;
              if (!over) begin
                res_load        = 1'b1;
                res_d.occupancy = OCC_W'(count_inc);
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_load = 1'b1;
              end else begin
                rd_en = 1'b1;
              end
            end
            OP_CLEAR: begin
              head_d   = '0;
              tail_d   = '0;
              count_d  = '0;
              res_load = 1'b1;
            end
            default: begin
              res_load        = 1'b1;
              res_d.occupancy = OCC_W'(count_q);
            end
          endcase
        end
      end

      // Read the head after the pushed entry has been written.
      ST_RD: begin
        rd_en = 1'b1;
      end

      // One head entry examined and possibly dropped per cycle.
      ST_WALK: begin
        if (rd_key && !first_q) begin
          res_load            = 1'b1;
          res_d.occupancy     = OCC_W'(count_q);
          res_d.dropped_count = DROP_W'(drop_q);
        end else begin
          head_d  = head_adv;
          count_d = count_dec;
          drop_d  = drop_inc;
          first_d = 1'b0;
          if (walk_done) begin
            res_load            = 1'b1;
            res_d.occupancy     = OCC_W'(count_dec);
            res_d.dropped_count = DROP_W'(drop_inc);
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_adv;
          end
        end
      end

      ST_POP: begin
        head_d               = head_adv;
        count_d              = count_dec;
        res_load             = 1'b1;
        res_d.pop_valid      = 1'b1;
        res_d.head_handle    = HANDLE_W'(rd_data_q[SW:1]);
        res_d.head_key_frame = rd_key;
        res_d.occupancy      = OCC_W'(count_dec);
      end

      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // The output register holds a result until the sink takes it.
  always_comb begin
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (out_chan_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      drop_q      <= '0;
      first_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      first_q     <= first_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Descriptor memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= {cmd_i.handle[SW-1:0], cmd_i.key};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_chan_o.valid          = res_valid_q;
  assign out_chan_o.pop_valid      = res_q.pop_valid;
  assign out_chan_o.head_handle    = res_q.head_handle;
  assign out_chan_o.head_key_frame = res_q.head_key_frame;
  assign out_chan_o.occupancy      = res_q.occupancy;
  assign out_chan_o.dropped_count  = res_q.dropped_count;

endmodule

>>> rtl/gop_aware_packet_queue.sv
// Top level of the key-frame-aware packet descriptor queue: APB register and the
// front/back instances. Depends on gapq_pkg, gapq_intf, gapq_front and gapq_back.
//
// A FIFO of packet descriptors (handle plus key-frame flag) that drops from the head
// when a push leaves more than max_entries entries: one key frame at the head, or all
// non-key entries up to the next key frame. Each command gives exactly one result.
// The back end works on one command at a time; its descriptor memory has one write port
// and one registered read port. A push without drop, a pop of an empty queue, a clear
// and a no-op load their result in the idle state. A pop that returns an entry reads the
// head, then loads its result in the pop state. A push that triggers a drop goes on to
// the read and walk states. A two-entry command queue and the output register let input
// and output transfers continue while a command is in progress. The limit in effect is
// the smaller of max_entries and QUEUE_DEPTH - 1; occupancy and dropped_count report the
// low seven bits of the internal counts. No clearing pass is needed after reset.
module gop_aware_packet_queue #(
  parameter int QUEUE_DEPTH = gapq_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = gapq_pkg::HANDLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gapq_pkg::APB_AW-1:0] paddr,
  input  logic [gapq_pkg::APB_DW-1:0] pwdata,
  output logic [gapq_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  gapq_in_if.sink                     in_chan_i,
  gapq_out_if.source                  out_chan_o
);
  import gapq_pkg::*;

  logic [MAXE_W-1:0] max_entries_q, max_entries_d;
  logic              cfg_wr;
  logic              cmd_valid;
  logic              cmd_ready;
  cmd_t              cmd;

  // Configuration register, written in the access phase of an APB transfer.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);

  always_comb begin
    max_entries_d = cfg_wr ? pwdata[MAXE_W-1:0] : max_entries_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
    end else begin
      max_entries_q <= max_entries_d;
    end
  end

  // Read back the limit; other addresses read as zero.
  always_comb begin
    if (paddr[2] == REG_MAX_ENTRIES) begin
      prdata = APB_DW'(max_entries_q);
    end else begin
      prdata = '0;
    end
  end

  gapq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan_i   (in_chan_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  gapq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .max_entries_i (max_entries_q),
    .out_chan_o    (out_chan_o)
  );

endmodule

>>> rtl/gapq_checker.sv
// Port-level checks of the key-frame-aware packet queue, bound to the top level.
// Depends on gapq_pkg and the top level gop_aware_packet_queue.
module gapq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          pop_valid_i,
  input logic [gapq_pkg::HANDLE_W-1:0] head_handle_i,
  input logic                          head_key_frame_i,
  input logic [gapq_pkg::OCC_W-1:0]    occupancy_i,
  input logic [gapq_pkg::DROP_W-1:0]   dropped_count_i
);
  import gapq_pkg::*;

  // A stalled result stays offered, with its fields other than head_key_frame unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pop_valid_i)
      && $stable(head_handle_i) && $stable(occupancy_i) && $stable(dropped_count_i))
    else $error("result changed while stalled");

  // A pop never reports dropped entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pop_valid_i |-> dropped_count_i == '0)
    else $error("pop result reports drops");

  // Without a popped entry the head fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pop_valid_i |-> head_handle_i == '0 && !head_key_frame_i)
    else $error("head fields set without a popped entry");

endmodule

bind gop_aware_packet_queue gapq_checker u_gapq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_chan_o.valid),
  .out_ready_i      (out_chan_o.ready),
  .pop_valid_i      (out_chan_o.pop_valid),
  .head_handle_i    (out_chan_o.head_handle),
  .head_key_frame_i (out_chan_o.head_key_frame),
  .occupancy_i      (out_chan_o.occupancy),
  .dropped_count_i  (out_chan_o.dropped_count)
);

>>> tb/sv/tb.sv
// Self-checking testbench for the key-frame-aware packet descriptor queue.
// Drives commands and limit writes, predicts each result and compares it field by field.
// Depends on gapq_pkg, gapq_intf and gop_aware_packet_queue.
module tb;
  import gapq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [OP_W-1:0] OPC_NOP = 2'd3;
  localparam logic [APB_AW-1:0] LIMIT_ADDR = {REG_MAX_ENTRIES, 2'b00};
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 119;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;

  typedef enum logic {
    ROW_SEND,
    ROW_LIMIT
  } row_kind_e;

  // One line of the directed stimulus: a command or a limit write.
  typedef struct {
    row_kind_e       kind;
    logic [OP_W-1:0] op;
    logic [31:0]     data;
    logic            key;
    bit              typed;
    res_t            want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  gapq_in_if  in_if ();
  gapq_out_if out_if ();

  gop_aware_packet_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_chan_i  (in_if),
    .out_chan_o (out_if)
  );

  // Shadow copy of the queue, used to predict every result.
  logic [HANDLE_W-1:0] q_handle [DEPTH];
  logic                q_key    [DEPTH];
  int                  q_rd;
  int                  q_wr;
  int                  q_fill;
  int                  fill_limit;

  res_t pending_results [$];
  stim_row_t directed [$];
  int errors;
  bit send_gaps;
  bit stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  function automatic void retire_head();
    q_rd = (q_rd + 1) % DEPTH;
    q_fill--;
  endfunction

  // Apply one command to the shadow queue and return the result it should give.
  function automatic res_t apply_command(logic [OP_W-1:0] op, logic [31:0] data, logic key);
    res_t r;
    int lim;
    int dropped;
    r = '0;
    dropped = 0;
    case (op)
      OPC_PUSH: begin
        lim = (fill_limit > DEPTH - 1) ? DEPTH - 1 : fill_limit;
        q_handle[q_wr] = data[HANDLE_W-1:0];
        q_key[q_wr] = key;
        q_wr = (q_wr + 1) % DEPTH;
        q_fill++;
        if (q_fill > lim) begin
          // A key frame at the head goes alone; otherwise walk to the next key frame.
          if (q_key[q_rd]) begin
            retire_head();
            dropped = 1;
          end else begin
            while (q_fill > 0 && !q_key[q_rd]) begin
              retire_head();
              dropped++;
            end
          end
        end
      end
      OPC_POP: begin
        if (q_fill > 0) begin
          r.pop_valid = 1'b1;
          r.head_handle = q_handle[q_rd];
          r.head_key_frame = q_key[q_rd];
          retire_head();
        end
      end
      OPC_CLEAR: begin
        q_rd = 0;
        q_wr = 0;
        q_fill = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = OCC_W'(q_fill);
    r.dropped_count = DROP_W'(dropped);
    return r;
  endfunction

  function automatic stim_row_t stim_row(row_kind_e kind, logic [OP_W-1:0] op,
                                         logic [31:0] data, int key = 0,
                                         int typed = 0, int pv = 0,
                                         logic [31:0] hh = '0, int hk = 0,
                                         int occ = 0, int drop = 0);
    stim_row_t s;
    s.kind = kind;
    s.op = op;
    s.data = data;
    s.key = key[0];
    s.typed = typed[0];
    s.want.pop_valid = pv[0];
    s.want.head_handle = hh;
    s.want.head_key_frame = hk[0];
    s.want.occupancy = OCC_W'(occ);
    s.want.dropped_count = DROP_W'(drop);
    return s;
  endfunction

  // Append one line to the directed stimulus.
  function automatic void add_row(stim_row_t row);
    directed = {directed, row};
  endfunction

  // Present one command, hold it until the transfer, then record its expected result.
  task automatic send_command(logic [OP_W-1:0] op, logic [31:0] data, logic key,
                              bit typed = 1'b0, res_t typed_res = '0);
    res_t predicted;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.packet_handle <= data;
    in_if.is_key_frame <= key;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = apply_command(op, data, key);
    pending_results = {pending_results, (typed ? typed_res : predicted)};
  endtask

  // Once the queue is idle, write the limit and read it back.
  task automatic set_limit(logic [APB_DW-1:0] value);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(APB_DW-MAXE_W){1'b0}}, value[MAXE_W-1:0]}) begin
      report_mismatch("max_entries readback", value[MAXE_W-1:0], prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    fill_limit = int'(value[MAXE_W-1:0]);
    @(posedge clk_i);
  endtask

  // Result side: random stall bursts on ready while enabled.
  initial begin : ready_gen
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare every result transfer with the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result without a pending command, occupancy", 0, out_if.occupancy);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_if.pop_valid !== want.pop_valid)
          report_mismatch("pop_valid", want.pop_valid, out_if.pop_valid);
        if (out_if.head_handle !== want.head_handle)
          report_mismatch("head_handle", want.head_handle, out_if.head_handle);
        if (out_if.head_key_frame !== want.head_key_frame)
          report_mismatch("head_key_frame", want.head_key_frame, out_if.head_key_frame);
        if (out_if.occupancy !== want.occupancy)
          report_mismatch("occupancy", want.occupancy, out_if.occupancy);
        if (out_if.dropped_count !== want.dropped_count)
          report_mismatch("dropped_count", want.dropped_count, out_if.dropped_count);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int lim;
    int push_pct;
    int key_pct;
    int gop_len;
    int gop_pos;
    int r;
    logic [OP_W-1:0] op;
    logic [31:0] data;
    logic key;
    logic [APB_DW-1:0] value;

    errors = 0;
    q_rd = 0;
    q_wr = 0;
    q_fill = 0;
    fill_limit = int'(MAX_ENTRIES_RST);
    send_gaps = 1'b1;
    stall_enable = 1'b1;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.opcode <= OPC_PUSH;
    in_if.packet_handle <= '0;
    in_if.is_key_frame <= 1'b0;

    // Directed part: empty pops, the unused opcode, extremes of the handle, clear,
    // single key-frame drops, walks that stop at a key frame or empty the queue,
    // and the limits of zero, one, two and the reset value.
    add_row(stim_row(ROW_SEND, OPC_POP, 32'h0, 0, 1, 0, 0, 0, 0, 0));
    add_row(stim_row(ROW_SEND, OPC_NOP, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0, 0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 1, 0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h0, 0, 1, 0, 0, 0, 2, 0));
    add_row(stim_row(ROW_SEND, OPC_POP, 32'h0, 0, 1, 1, 32'hFFFF_FFFF, 1, 1, 0));
    add_row(stim_row(ROW_SEND, OPC_POP, 32'hFFFF_FFFF, 1, 1, 1, 32'h0, 0, 0, 0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'hA5A5_A5A5, 0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h5A5A_5A5A, 1));
    add_row(stim_row(ROW_SEND, OPC_NOP, 32'h0, 0, 1, 0, 0, 0, 2, 0));
    add_row(stim_row(ROW_SEND, OPC_CLEAR, 32'h1234_5678, 1, 1, 0, 0, 0, 0, 0));
    add_row(stim_row(ROW_SEND, OPC_POP, 32'h0, 0, 1, 0, 0, 0, 0, 0));
    add_row(stim_row(ROW_LIMIT, OPC_NOP, 32'd2));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h1111_1111, 0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h2222_2222, 0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h3333_3333, 1, 1, 0, 0, 0, 1, 2));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h4444_4444, 0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h5555_5555, 0, 1, 0, 0, 0, 2, 1));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h6666_6666, 0, 1, 0, 0, 0, 0, 3));
    add_row(stim_row(ROW_LIMIT, OPC_NOP, 32'd0));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h7777_7777, 1, 1, 0, 0, 0, 0, 1));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h8888_8888, 0, 1, 0, 0, 0, 0, 1));
    add_row(stim_row(ROW_SEND, OPC_POP, 32'h0, 0, 1, 0, 0, 0, 0, 0));
    add_row(stim_row(ROW_LIMIT, OPC_NOP, 32'd1));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h8000_0001, 1));
    add_row(stim_row(ROW_SEND, OPC_PUSH, 32'h7FFF_FFFE, 1, 1, 0, 0, 0, 1, 1));
    add_row(stim_row(ROW_SEND, OPC_POP, 32'h0, 0, 1, 1, 32'h7FFF_FFFE, 1, 0, 0));
    add_row(stim_row(ROW_LIMIT, OPC_NOP, 32'd63));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_LIMIT) begin
        set_limit(directed[i].data);
      end else begin
        send_command(directed[i].op, directed[i].data, directed[i].key,
                     directed[i].typed, directed[i].want);
      end
    end

    // Random part: each phase sets a limit, a push share and a key-frame pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gop_len = 0;
      key_pct = 50;
      case (p)
        0:  begin lim = 63; push_pct = 92; key_pct = 0; end
        1:  begin lim = 63; push_pct = 85; gop_len = 12; end
        2:  begin lim = 0;  push_pct = 60; key_pct = 50; end
        3:  begin lim = 1;  push_pct = 55; key_pct = 40; end
        4:  begin lim = 2;  push_pct = 65; gop_len = 3; end
        5:  begin lim = $urandom_range(3, 62); push_pct = 75; gop_len = 8; end
        6:  begin lim = 63; push_pct = 90; key_pct = 100; end
        7:  begin lim = 5;  push_pct = 60; key_pct = 20; end
        8:  begin lim = $urandom_range(1, 62); push_pct = 70; gop_len = $urandom_range(2, 20); end
        9:  begin lim = 32; push_pct = 80; gop_len = 16; end
        10: begin lim = 63; push_pct = 80; gop_len = 10; end
        default: begin lim = $urandom_range(0, 63); push_pct = 65; key_pct = 30; end
      endcase
      // Idle bursts on both sides, one side or neither; none in the last phases.
      send_gaps = (p < RANDOM_PHASES - 2) && (p % 4 == 0 || p % 4 == 1);
      stall_enable = (p < RANDOM_PHASES - 2) && (p % 4 == 0 || p % 4 == 2);
      value = 32'(lim);
      if (p % 2 == 1) value = ($urandom & 32'hFFFF_FFC0) | value;
      set_limit(value);
      gop_pos = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        data = $urandom;
        if (r < 2) begin
          op = OPC_CLEAR;
        end else if (r < 5) begin
          op = OPC_NOP;
        end else if (r < 5 + push_pct) begin
          op = OPC_PUSH;
        end else begin
          op = OPC_POP;
        end
        // Group-of-pictures pattern with occasional broken groups, or a plain share.
        if (gop_len > 0) begin
          key = (gop_pos == 0);
          if ($urandom_range(0, 19) == 0) key = ~key;
          if (op == OPC_PUSH) gop_pos = (gop_pos + 1) % gop_len;
        end else begin
          key = ($urandom_range(0, 99) < key_pct);
        end
        send_command(op, data, key);
      end
    end

    // Wait for every outstanding result, then a margin for stray transfers.
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
